@@ design/ita_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, codes and character helpers for the integer to ASCII
// formatter.
// ----------------------------------------------------------------------------
package ita_pkg;

    localparam int NUM_DIGITS  = 20;
    localparam int DIGIT_AW    = $clog2(NUM_DIGITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int CONV_STEPS  = 16;
    localparam int STEP_AW     = $clog2(CONV_STEPS);
    localparam int NIL_LEN     = 5;
    localparam int NIL_AW      = $clog2(NIL_LEN);

    localparam logic [30:0] COUNT_MAX = 31'h7fff_ffff;

    localparam logic [1:0] OP_CHAR     = 2'd0;
    localparam logic [1:0] OP_SIGNED   = 2'd1;
    localparam logic [1:0] OP_UNSIGNED = 2'd2;
    localparam logic [1:0] OP_POINTER  = 2'd3;

    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_N       = 8'h6e;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_L       = 8'h6c;
    localparam logic [7:0] CH_RPAREN  = 8'h29;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_NIL,
        KIND_NUM
    } kind_t;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_HEX
    } prefix_t;

    typedef struct packed {
        kind_t       kind;
        prefix_t     prefix;
        logic        hex;
        logic        upper;
        logic [63:0] mag;
    } item_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + {4'b0, d};
        end
        else begin
            base       = upper ? CH_UPPER_A : CH_LOWER_A;
            digit_char = base + {4'b0, d} - 8'd10;
        end
    endfunction

    function automatic logic [7:0] nil_char(input logic [NIL_AW-1:0] idx);
        unique case (idx)
            3'd0:    nil_char = CH_LPAREN;
            3'd1:    nil_char = CH_N;
            3'd2:    nil_char = CH_I;
            3'd3:    nil_char = CH_L;
            default: nil_char = CH_RPAREN;
        endcase
    endfunction

endpackage

@@ design/ita_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_front
// Accepts conversion requests, works out the run shape (raw char, nil,
// number with optional prefix) and the magnitude, and hands it to the queue.
// ----------------------------------------------------------------------------
module ita_front
    import ita_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic        radix_hex,
    input  logic        upper_case,
    input  logic [63:0] value,
    output logic        push_valid,
    input  logic        push_ready,
    output item_t       push_item
);

    logic  slot_valid_reg;
    logic  slot_valid_next;
    item_t slot_reg;
    item_t class_item;
    logic  accept;

    always_comb
    begin
        class_item        = '0;
        class_item.kind   = KIND_NUM;
        class_item.prefix = PFX_NONE;
        class_item.hex    = radix_hex;
        class_item.upper  = upper_case;
        class_item.mag    = value;
        unique case (opcode)
            OP_CHAR:
            begin
                class_item.kind = KIND_CHAR;
                class_item.mag  = {56'b0, value[7:0]};
            end
            OP_SIGNED:
            begin
                if (value[31])
                begin
                    class_item.prefix = PFX_MINUS;
                    class_item.mag    = {32'b0, 32'(~value[31:0] + 32'd1)};
                end
                else
                begin
                    class_item.mag = {32'b0, value[31:0]};
                end
            end
            OP_UNSIGNED:
            begin
                class_item.mag = value;
            end
            default:
            begin
                class_item.hex   = 1'b1;
                class_item.upper = 1'b0;
                if (value == 64'd0)
                begin
                    class_item.kind = KIND_NIL;
                end
                else
                begin
                    class_item.prefix = PFX_HEX;
                end
            end
        endcase
    end

    assign in_ready   = !slot_valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = slot_valid_reg;
    assign push_item  = slot_reg;

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        if (accept)
        begin
            slot_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            slot_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg <= class_item;
        end
    end

endmodule

@@ design/ita_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_queue
// Short first-in first-out queue of classified requests between the front
// and back parts.
// ----------------------------------------------------------------------------
module ita_queue
    import ita_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   cnt_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = cnt_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ design/ita_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_back
// Takes one classified request at a time, converts the magnitude to digits
// (four binary bits per cycle into packed decimal, or nibbles for hex) and
// emits the run via an output register, one character per cycle unless stalled.
// ----------------------------------------------------------------------------
module ita_back
    import ita_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  item_t       pop_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  ch,
    output logic        last,
    output logic [30:0] total_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIZE,
        S_PREFIX,
        S_DIGIT,
        S_CHAR,
        S_NIL
    } state_t;

    typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

    state_t              state_reg;
    item_t               item_reg;
    bcd_t                bcd_reg;
    logic [63:0]         bin_reg;
    logic [STEP_AW-1:0]  step_reg;
    logic [DIGIT_AW-1:0] pos_reg;
    logic                pfx_idx_reg;
    logic                out_valid_reg;
    logic [7:0]          ch_reg;
    logic                last_reg;
    logic [30:0]         count_reg;

    bcd_t                dab_bcd;
    logic [63:0]         dab_bin;
    logic [DIGIT_AW-1:0] msd;
    logic                slot_free;
    logic                emit;
    logic [7:0]          emit_ch;
    logic                emit_last;
    logic [30:0]         count_next;

    // shift-and-add-3, four bits per cycle
    always_comb
    begin
        dab_bcd = bcd_reg;
        dab_bin = bin_reg;
        for (int s = 0; s < 4; s++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (dab_bcd[d] >= 4'd5)
                begin
                    dab_bcd[d] = dab_bcd[d] + 4'd3;
                end
            end
            {dab_bcd, dab_bin} = {dab_bcd, dab_bin} << 1;
        end
    end

    // most significant non-zero digit
    always_comb
    begin
        msd = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[d] != 4'd0)
            begin
                msd = DIGIT_AW'(d);
            end
        end
    end

    assign slot_free  = !out_valid_reg || out_ready;
    assign pop_ready  = state_reg == S_IDLE;
    assign count_next = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 31'd1;

    always_comb
    begin
        emit      = 1'b0;
        emit_ch   = CH_ZERO;
        emit_last = 1'b0;
        case (state_reg)
            S_PREFIX:
            begin
                emit    = slot_free;
                emit_ch = (item_reg.prefix == PFX_MINUS) ? CH_MINUS :
                          (pfx_idx_reg ? CH_X : CH_ZERO);
            end
            S_DIGIT:
            begin
                emit      = slot_free;
                emit_ch   = digit_char(bcd_reg[pos_reg], item_reg.upper);
                emit_last = pos_reg == '0;
            end
            S_CHAR:
            begin
                emit      = slot_free;
                emit_ch   = item_reg.mag[7:0];
                emit_last = 1'b1;
            end
            S_NIL:
            begin
                emit      = slot_free;
                emit_ch   = nil_char(NIL_AW'(pos_reg));
                emit_last = pos_reg == DIGIT_AW'(NIL_LEN - 1);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ch_reg        <= '0;
            last_reg      <= 1'b0;
            count_reg     <= '0;
            step_reg      <= '0;
            pos_reg       <= '0;
            pfx_idx_reg   <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                ch_reg        <= emit_ch;
                last_reg      <= emit_last;
                count_reg     <= count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        pos_reg     <= '0;
                        step_reg    <= '0;
                        pfx_idx_reg <= 1'b0;
                        case (pop_item.kind)
                            KIND_CHAR: state_reg <= S_CHAR;
                            KIND_NIL:  state_reg <= S_NIL;
                            default:   state_reg <= pop_item.hex ? S_SIZE : S_CONV;
                        endcase
                    end
                end
                S_CONV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_AW'(CONV_STEPS - 1))
                    begin
                        state_reg <= S_SIZE;
                    end
                end
                S_SIZE:
                begin
                    pos_reg   <= msd;
                    state_reg <= (item_reg.prefix == PFX_NONE) ? S_DIGIT : S_PREFIX;
                end
                S_PREFIX:
                begin
                    if (emit)
                    begin
                        if (item_reg.prefix == PFX_MINUS || pfx_idx_reg)
                        begin
                            state_reg <= S_DIGIT;
                        end
                        pfx_idx_reg <= 1'b1;
                    end
                end
                S_DIGIT:
                begin
                    if (emit)
                    begin
                        if (emit_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            pos_reg <= pos_reg - 1'b1;
                        end
                    end
                end
                S_CHAR:
                begin
                    if (emit)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_NIL:
                begin
                    if (emit)
                    begin
                        pos_reg <= pos_reg + 1'b1;
                        if (emit_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && pop_valid)
        begin
            item_reg <= pop_item;
            bcd_reg  <= pop_item.hex ? bcd_t'({16'b0, pop_item.mag}) : '0;
            bin_reg  <= pop_item.mag;
        end
        else if (state_reg == S_CONV)
        begin
            bcd_reg <= dab_bcd;
            bin_reg <= dab_bin;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ch          = ch_reg;
    assign last        = last_reg;
    assign total_count = count_reg;

endmodule

@@ design/integer_to_ascii_formatter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Turns one conversion request (raw char, signed 32-bit, unsigned 64-bit or
// pointer) into a run of ASCII characters with the final one marked.
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready carries opcode, radix_hex, upper_case and
//   value; output channel out_valid/out_ready carries ch, last and
//   total_count, one character per transfer, last set on the run's end.
//   the front registers and classifies a request, a two-entry queue holds up
//   to two more, and the back converts and emits one request at a time.
//   an accepted request passes through the front's register and the queue
//   to the back, which converts a decimal number to packed decimal four
//   bits at a time and then, for hex or decimal, sizes the run before its
//   first character goes to the output register. a run holds up to 20
//   characters, and the back takes the next request once it has passed
//   the run's last character to the output register.
//   while the receiver stalls, the output register holds its character and
//   the front keeps taking requests until it and the queue are full.
//   reset clears the queue, the front's slot, the character count and the output valid.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
    import ita_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic        radix_hex,
    input  logic        upper_case,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  ch,
    output logic        last,
    output logic [30:0] total_count
);

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    ita_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .radix_hex  (radix_hex),
        .upper_case (upper_case),
        .value      (value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    ita_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    ita_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ch          (ch),
        .last        (last),
        .total_count (total_count)
    );

endmodule

@@ design/ita_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_checker
// Port-level checks of the formatter's output channel and character count.
// ----------------------------------------------------------------------------
module ita_checker
    import ita_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  ch,
    input logic        last,
    input logic [30:0] total_count
);

    logic        seen_reg;
    logic [30:0] prev_reg;
    logic [30:0] expect_cnt;

    assign expect_cnt = (prev_reg == COUNT_MAX) ? COUNT_MAX : prev_reg + 31'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            prev_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            seen_reg <= 1'b1;
            prev_reg <= total_count;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ch) && $stable(last)
            && $stable(total_count))
        else $error("output request changed while stalled");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_reg |-> total_count == expect_cnt)
        else $error("character count did not advance by one");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> total_count != 31'd0)
        else $error("character count zero on an emitted character");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");

endmodule

bind integer_to_ascii_formatter ita_checker u_checker (.*);
